>>> sv/cpps_pkg.sv
// Shared types and fixed widths of the closest pair search block.
`default_nettype none

package cpps_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 34;
    localparam int OBS_W   = 16;
    localparam int SLOT_W  = 12;
    localparam int COUNT_W = 13;
    localparam int ABS_W   = 16;
    localparam int SQ_W    = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        logic               op;
        coord_t             coord_x;
        coord_t             coord_y;
        coord_t             coord_z;
        logic [SLOT_W-1:0]  mesh_slot;
        logic               last_query;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0]  min_dist_sq;
        logic [OBS_W-1:0]   obstacle_index;
        logic [SLOT_W-1:0]  mesh_index;
        logic               found;
    } out_item_t;

    typedef logic [COUNT_W-1:0] cfg_item_t;

endpackage

`default_nettype wire

>>> sv/cpps_chan.sv
// Valid/ready channel interface carrying one item of a chosen payload type.
`default_nettype none

interface cpps_chan #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/cpps_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module cpps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/cpps_dist.sv
// Shared pipelined squared distance unit: one point pair enters per cycle.
`default_nettype none

module cpps_dist #(
    parameter int IDX_W = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire cpps_pkg::point_t              query,
    input  wire cpps_pkg::point_t              mesh,
    input  wire logic [IDX_W-1:0]              in_idx,
    output logic                               out_valid,
    output logic [cpps_pkg::DIST_W-1:0]        out_dist,
    output logic [IDX_W-1:0]                   out_idx,
    output logic                               busy
);

    logic                          v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]              i1_reg, i2_reg, i3_reg;
    logic [cpps_pkg::ABS_W-1:0]    ax_reg, ay_reg, az_reg;
    logic [cpps_pkg::ABS_W-1:0]    ax_next, ay_next, az_next;
    logic [cpps_pkg::SQ_W-1:0]     sx_reg, sy_reg, sz_reg;
    logic [cpps_pkg::DIST_W-1:0]   sum_reg, sum_next;

    // Absolute difference of one coordinate pair, exact in 16 unsigned bits.
    function automatic logic [cpps_pkg::ABS_W-1:0] abs_diff(
        input cpps_pkg::coord_t a,
        input cpps_pkg::coord_t b
    );
        logic signed [cpps_pkg::COORD_W:0] d;
        logic signed [cpps_pkg::COORD_W:0] m;
        d = {a[cpps_pkg::COORD_W-1], a} - {b[cpps_pkg::COORD_W-1], b};
        m = d[cpps_pkg::COORD_W] ? -d : d;
        return m[cpps_pkg::ABS_W-1:0];
    endfunction

    assign ax_next  = abs_diff(query.x, mesh.x);
    assign ay_next  = abs_diff(query.y, mesh.y);
    assign az_next  = abs_diff(query.z, mesh.z);
    assign sum_next = cpps_pkg::DIST_W'(sx_reg) + cpps_pkg::DIST_W'(sy_reg)
                    + cpps_pkg::DIST_W'(sz_reg);

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Datapath: differences, then squares, then the sum.
    always_ff @(posedge clk)
    begin
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        i1_reg  <= in_idx;
        sx_reg  <= cpps_pkg::SQ_W'(ax_reg) * cpps_pkg::SQ_W'(ax_reg);
        sy_reg  <= cpps_pkg::SQ_W'(ay_reg) * cpps_pkg::SQ_W'(ay_reg);
        sz_reg  <= cpps_pkg::SQ_W'(az_reg) * cpps_pkg::SQ_W'(az_reg);
        i2_reg  <= i1_reg;
        sum_reg <= sum_next;
        i3_reg  <= i2_reg;
    end

    assign out_valid = v3_reg;
    assign out_dist  = sum_reg;
    assign out_idx   = i3_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

`default_nettype wire

>>> sv/closest_pair_point_sets.sv
// Closest pair search between a stored mesh point set and streamed obstacle points.
// A load writes one store slot; a query with n = min(mesh_count, MESH_DEPTH) > 0 makes
// n RAM reads into the shared distance pipe, waits for its drain, then takes the count step.
// An empty query skips the reads; a last query then shows its result once no old one is held.
// Throughput: one load per cycle while idle; a query is taken only once the last one is done.
// Reset: clears running minimum, query counter, mesh_count and result valid, not the store.
`default_nettype none

module closest_pair_point_sets #(
    parameter int MESH_DEPTH  = 4096,
    parameter int MAX_QUERIES = 65536
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cpps_chan.sink    point,
    cpps_chan.source  result,
    cpps_chan.sink    cfg
);

    localparam int AW   = (MESH_DEPTH > 1) ? $clog2(MESH_DEPTH) : 1;
    localparam int CW   = $clog2(MESH_DEPTH + 1);
    localparam int QTOP = (MAX_QUERIES - 1 > 65535) ? 65535 : MAX_QUERIES - 1;
    localparam int LW   = 17;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_POST   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [CW-1:0]                     scan_reg, scan_next;
    logic [CW-1:0]                     n_reg, n_next;
    logic [cpps_pkg::COUNT_W-1:0]      mesh_count_reg;
    cpps_pkg::point_t                  query_reg;
    logic                              last_reg;
    logic                              rd_valid_reg, rd_valid_next;
    logic [AW-1:0]                     rd_idx_reg;
    logic [cpps_pkg::DIST_W-1:0]       best_dist_reg, best_dist_next;
    logic [cpps_pkg::OBS_W-1:0]        best_obs_reg, best_obs_next;
    logic [cpps_pkg::SLOT_W-1:0]       best_mesh_reg, best_mesh_next;
    logic                              found_reg, found_next;
    logic [cpps_pkg::OBS_W-1:0]        qcnt_reg, qcnt_next;
    logic                              out_valid_reg, out_valid_next;
    cpps_pkg::out_item_t               out_data_reg, out_data_next;

    cpps_pkg::in_item_t                item;
    logic                              accept;
    logic                              load_we;
    logic [LW-1:0]                     limit;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    cpps_pkg::point_t                  wr_point;
    cpps_pkg::point_t                  rd_point;
    logic                              d_valid;
    logic [cpps_pkg::DIST_W-1:0]       d_dist;
    logic [AW-1:0]                     d_idx;
    logic                              d_busy;
    logic                              take_best;

    assign item    = point.data;
    assign accept  = point.valid & point.ready;
    assign load_we = accept && (item.op == cpps_pkg::OP_LOAD)
                  && (LW'(item.mesh_slot) < LW'(MESH_DEPTH));

    // Number of slots searched, clipped to the store depth.
    assign limit = (LW'(mesh_count_reg) > LW'(MESH_DEPTH)) ? LW'(MESH_DEPTH)
                                                           : LW'(mesh_count_reg);

    assign point.ready  = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign wr_point.x = item.coord_x;
    assign wr_point.y = item.coord_y;
    assign wr_point.z = item.coord_z;

    assign rd_en   = (state_reg == S_SCAN);
    assign rd_addr = scan_reg[AW-1:0];

    cpps_ram #(
        .WIDTH ($bits(cpps_pkg::point_t)),
        .DEPTH (MESH_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(item.mesh_slot)),
        .wdata (wr_point),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_point)
    );

    cpps_dist #(
        .IDX_W (AW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .query     (query_reg),
        .mesh      (rd_point),
        .in_idx    (rd_idx_reg),
        .out_valid (d_valid),
        .out_dist  (d_dist),
        .out_idx   (d_idx),
        .busy      (d_busy)
    );

    // Strict less-than keeps the earliest pair on a tie.
    assign take_best = d_valid && (!found_reg || (d_dist < best_dist_reg));

    // Sequencer and running minimum.
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        n_next         = n_reg;
        rd_valid_next  = rd_en;
        best_dist_next = best_dist_reg;
        best_obs_next  = best_obs_reg;
        best_mesh_next = best_mesh_reg;
        found_next     = found_reg;
        qcnt_next      = qcnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take_best)
        begin
            best_dist_next = d_dist;
            best_obs_next  = qcnt_reg;
            best_mesh_next = cpps_pkg::SLOT_W'(d_idx);
            found_next     = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.op == cpps_pkg::OP_QUERY))
                begin
                    n_next     = CW'(limit);
                    scan_next  = '0;
                    state_next = (limit == '0) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_next == n_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !d_busy)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (qcnt_reg < cpps_pkg::OBS_W'(QTOP))
                begin
                    qcnt_next = qcnt_reg + 1'b1;
                end
                state_next = last_reg ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        out_data_next.min_dist_sq    = best_dist_reg;
                        out_data_next.obstacle_index = best_obs_reg;
                        out_data_next.mesh_index     = best_mesh_reg;
                        out_data_next.found          = 1'b1;
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    best_dist_next = '1;
                    best_obs_next  = '0;
                    best_mesh_next = '0;
                    found_next     = 1'b0;
                    qcnt_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and running state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            n_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            best_dist_reg  <= '1;
            best_obs_reg   <= '0;
            best_mesh_reg  <= '0;
            found_reg      <= 1'b0;
            qcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
            mesh_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            n_reg         <= n_next;
            rd_valid_reg  <= rd_valid_next;
            best_dist_reg <= best_dist_next;
            best_obs_reg  <= best_obs_next;
            best_mesh_reg <= best_mesh_next;
            found_reg     <= found_next;
            qcnt_reg      <= qcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                mesh_count_reg <= cfg.data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        rd_idx_reg   <= rd_addr;
        if (accept && (item.op == cpps_pkg::OP_QUERY))
        begin
            query_reg <= wr_point;
            last_reg  <= item.last_query;
        end
    end

    // Distances only arrive while a query is being searched.
    assert property (@(posedge clk) disable iff (!rst_n)
        d_valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("distance result outside a search");

    // The obstacle ordinal never passes its top.
    assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= cpps_pkg::OBS_W'(QTOP))
        else $error("query counter beyond its top");

    // A new result only comes out of the finishing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result raised outside the finishing step");

    // The counter moves on only after the distance pipe has drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST) |-> (!rd_valid_reg && !d_busy))
        else $error("query closed with distances in flight");

    // The scan index stays below the slot count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg < n_reg))
        else $error("scan index beyond the slot count");

endmodule

`default_nettype wire
